/* hw/rtl/palloc_pkg.sv */
// palloc_pkg: shared types and codes for the page allocator
// command codes, status codes and the decoded command record passed front to back
// no dependencies
package palloc_pkg;

   localparam logic [2:0] CMD_ALLOC   = 3'd0;
   localparam logic [2:0] CMD_FREE    = 3'd1;
   localparam logic [2:0] CMD_INC     = 3'd2;
   localparam logic [2:0] CMD_DEC     = 3'd3;
   localparam logic [2:0] CMD_GET     = 3'd4;
   localparam logic [2:0] CMD_NFREE   = 3'd5;

   localparam logic [16:0] FREE_MAX   = 17'h1FFFF;

   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_INC   = 3'd2,
      OP_DEC   = 3'd3,
      OP_GET   = 3'd4,
      OP_NFREE = 3'd5,
      OP_NOP   = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ADDR  = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_BUSY      = 3'd3,
      ST_OVERFLOW  = 3'd4,
      ST_UNDERFLOW = 3'd5
   } status_type;

   // decoded command, the page index travels beside it
   typedef struct packed {
      op_type op;
      logic   addr_ok;
   } cmd_info_type;

endpackage

/* hw/rtl/page_allocator_with_refcounts_top.sv */
// page_allocator_with_refcounts_top: top level of the page frame allocator
// depends on palloc_pkg, palloc_front, palloc_queue, palloc_back and, through palloc_back, palloc_ram
//
// Page frame allocator with a LIFO free list and per-page reference counts. Each command
// passes the execute back end in two steps (the read of the count and link memories on issue,
// then the update of both and the load of the result register), and the back end takes no
// new command until that one is done and the result register is empty or being taken. The
// request is held in the queue, then read, then executed into the result register.
// A two-entry queue behind the decode front accepts commands until it is full while a result
// waits to be taken. After reset the back end clears the count memory, one page per cycle,
// over every page index; req_tready stays low during that pass while csr writes are taken as
// usual. Addresses must be PAGE_BYTES-aligned and lie between first_usable_page and
// NUM_PAGES-1 pages; the free list is built by software with free commands.
module page_allocator_with_refcounts_top
   import palloc_pkg::*;
#(
   parameter int NUM_PAGES  = 65536,
   parameter int PAGE_BYTES = 4096,
   parameter int REF_BITS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,     // first_usable_page
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] phys_addr
   input  logic [2:0]  req_tuser,    // [2:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata     // [2:0] status, [30:3] page_addr, [38:31] ref_count,
                                     // [55:39] free_count
);

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int ENT_W = $bits(cmd_info_type) + IDX_W;

   cmd_info_type      front_info;
   logic [IDX_W-1:0]  front_idx;
   logic              q_push, q_ready, q_pop, q_valid;
   logic [ENT_W-1:0]  q_data;
   cmd_info_type      back_info;
   logic [IDX_W-1:0]  back_idx;
   logic              clearing;
   logic [2:0]        status;
   logic [27:0]       page_addr;
   logic [7:0]        ref_count;
   logic [16:0]       free_count;

   assign csr_ready  = 1'b1;
   assign req_tready = q_ready && !clearing;
   assign q_push     = req_tvalid && req_tready;

   palloc_front #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (req_tuser),
      .phys_addr (req_tdata),
      .info      (front_info),
      .page_idx  (front_idx)
   );

   palloc_queue #(.WIDTH(ENT_W), .DEPTH(2)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({front_idx, front_info}),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   assign back_info = q_data[$bits(cmd_info_type)-1:0];
   assign back_idx  = q_data[ENT_W-1:$bits(cmd_info_type)];

   palloc_back #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES),
      .REF_BITS   (REF_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_valid),
      .cmd_info       (back_info),
      .cmd_idx        (back_idx),
      .cmd_pop        (q_pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_status     (status),
      .rsp_page_addr  (page_addr),
      .rsp_ref_count  (ref_count),
      .rsp_free_count (free_count)
   );

   assign rsp_tdata = {free_count, ref_count, page_addr, status};

endmodule

/* hw/rtl/palloc_ram.sv */
// palloc_ram: generic single-port-write, single-port-read ram with registered read
// no contents reset; used for the link table and the reference counts
// no dependencies
module palloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/palloc_front.sv */
// palloc_front: command decode and physical address check
// holds the first usable page register; depends on palloc_pkg
module palloc_front
   import palloc_pkg::*;
#(
   parameter int NUM_PAGES  = 65536,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [15:0]                  csr_data,
   input  logic [2:0]                   cmd,
   input  logic [31:0]                  phys_addr,
   output cmd_info_type                 info,
   output logic [$clog2(NUM_PAGES)-1:0] page_idx
);

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int OFS_W = $clog2(PAGE_BYTES);
   localparam int PN_W  = 32 - OFS_W;
   localparam logic [31:0] PAGE_LIMIT = 32'(NUM_PAGES);

   logic [15:0]     first_page_ff;
   logic [15:0]     first_page_in;
   logic [PN_W-1:0] page_num;
   logic            aligned;
   logic            in_range;

   always_comb begin
      first_page_in = first_page_ff;
      if (csr_valid) begin
         first_page_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
      end else begin
         first_page_ff <= first_page_in;
      end
   end

   assign page_num = phys_addr[31:OFS_W];
   assign aligned  = (phys_addr[OFS_W-1:0] == '0);
   assign in_range = (32'(page_num) >= 32'(first_page_ff)) && (32'(page_num) < PAGE_LIMIT);
   assign page_idx = IDX_W'(page_num);

   always_comb begin
      info.addr_ok = aligned && in_range;
      unique case (cmd)
         CMD_ALLOC: info.op = OP_ALLOC;
         CMD_FREE:  info.op = OP_FREE;
         CMD_INC:   info.op = OP_INC;
         CMD_DEC:   info.op = OP_DEC;
         CMD_GET:   info.op = OP_GET;
         CMD_NFREE: info.op = OP_NFREE;
         default:   info.op = OP_NOP;
      endcase
   end

endmodule

/* hw/rtl/palloc_queue.sv */
// palloc_queue: small register fifo between the decode front and the execute back
// depth must be a power of two; no dependencies
module palloc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/palloc_back.sv */
// palloc_back: executes decoded commands against the link and count memories
// owns free list head, free page counter, count clearing pass and the result register
// depends on palloc_pkg and palloc_ram
module palloc_back
   import palloc_pkg::*;
#(
   parameter int NUM_PAGES  = 65536,
   parameter int PAGE_BYTES = 4096,
   parameter int REF_BITS   = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  cmd_info_type                 cmd_info,
   input  logic [$clog2(NUM_PAGES)-1:0] cmd_idx,
   output logic                         cmd_pop,
   output logic                         clearing,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic [27:0]                  rsp_page_addr,
   output logic [7:0]                   rsp_ref_count,
   output logic [16:0]                  rsp_free_count
);

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int OFS_W = $clog2(PAGE_BYTES);
   localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(NUM_PAGES - 1);
   localparam logic [REF_BITS-1:0] REF_MAX  = '1;

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic              nonempty_ff, nonempty_in;
   logic [16:0]       free_ff, free_in;
   cmd_info_type      cur_ff, cur_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        status_ff, status_in;
   logic [27:0]       addr_ff, addr_in;
   logic [7:0]        refs_ff, refs_in;

   logic                refs_we;
   logic [IDX_W-1:0]    refs_waddr;
   logic [REF_BITS-1:0] refs_wdata;
   logic [REF_BITS-1:0] refs_rdata;
   logic                link_we;
   logic [IDX_W:0]      link_rdata;
   logic [IDX_W-1:0]    rd_idx;
   logic                issue;

   logic [REF_BITS-1:0] r_new;
   logic [15:0]         r_out_wide;
   logic [63:0]         addr_wide;

   assign clearing = (state_ff == S_CLEAR);
   assign issue    = (state_ff == S_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop  = issue;
   assign rd_idx   = (cmd_info.op == OP_ALLOC) ? head_ff : cmd_idx;
   assign refs_waddr = clearing ? clr_ff : tgt_ff;

   // link word carries the valid bit above the next page index
   palloc_ram #(.WIDTH(IDX_W + 1), .DEPTH(NUM_PAGES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (tgt_ff),
      .wr_data ({nonempty_ff, head_ff}),
      .rd_en   (issue),
      .rd_addr (head_ff),
      .rd_data (link_rdata)
   );

   palloc_ram #(.WIDTH(REF_BITS), .DEPTH(NUM_PAGES)) u_refs_ram (
      .clock   (clock),
      .wr_en   (refs_we),
      .wr_addr (refs_waddr),
      .wr_data (refs_wdata),
      .rd_en   (issue),
      .rd_addr (rd_idx),
      .rd_data (refs_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      head_in      = head_ff;
      nonempty_in  = nonempty_ff;
      free_in      = free_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      refs_in      = refs_ff;
      refs_we      = 1'b0;
      refs_wdata   = '0;
      link_we      = 1'b0;
      r_new        = refs_rdata;
      r_out_wide   = '0;
      addr_wide    = 64'(head_ff) << OFS_W;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            refs_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (issue) begin
               cur_in   = cmd_info;
               tgt_in   = rd_idx;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            addr_in   = '0;
            if ((cur_ff.op == OP_FREE || cur_ff.op == OP_INC || cur_ff.op == OP_DEC ||
                 cur_ff.op == OP_GET) && !cur_ff.addr_ok) begin
               status_in = ST_BAD_ADDR;
            end else begin
               unique case (cur_ff.op)
                  OP_ALLOC: begin
                     if (!nonempty_ff) begin
                        status_in = ST_EMPTY;
                     end else if (refs_rdata != '0) begin
                        status_in  = ST_BUSY;
                        r_out_wide = 16'(refs_rdata);
                     end else begin
                        head_in     = link_rdata[IDX_W-1:0];
                        nonempty_in = link_rdata[IDX_W];
                        refs_we     = 1'b1;
                        refs_wdata  = REF_BITS'(1);
                        r_out_wide  = 16'(1);
                        addr_in     = addr_wide[27:0];
                        if (free_ff != '0) begin
                           free_in = free_ff - 1'b1;
                        end
                     end
                  end
                  OP_FREE: begin
                     if (refs_rdata > REF_BITS'(1)) begin
                        r_new = refs_rdata - 1'b1;
                     end else begin
                        r_new       = '0;
                        link_we     = 1'b1;
                        head_in     = tgt_ff;
                        nonempty_in = 1'b1;
                        if (free_ff != FREE_MAX) begin
                           free_in = free_ff + 1'b1;
                        end
                     end
                     refs_we    = 1'b1;
                     refs_wdata = r_new;
                     r_out_wide = 16'(r_new);
                  end
                  OP_INC: begin
                     if (refs_rdata == REF_MAX) begin
                        status_in = ST_OVERFLOW;
                     end else begin
                        r_new = refs_rdata + 1'b1;
                     end
                     refs_we    = 1'b1;
                     refs_wdata = r_new;
                     r_out_wide = 16'(r_new);
                  end
                  OP_DEC: begin
                     if (refs_rdata == '0) begin
                        status_in = ST_UNDERFLOW;
                     end else begin
                        r_new = refs_rdata - 1'b1;
                     end
                     refs_we    = 1'b1;
                     refs_wdata = r_new;
                     r_out_wide = 16'(r_new);
                  end
                  OP_GET: begin
                     r_out_wide = 16'(refs_rdata);
                  end
                  default: begin
                  end
               endcase
            end
            refs_in      = r_out_wide[7:0];
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      tgt_ff    <= tgt_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      refs_ff   <= refs_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_page_addr  = addr_ff;
   assign rsp_ref_count  = refs_ff;
   assign rsp_free_count = free_ff;

endmodule

/* hw/rtl/palloc_checker.sv */
// palloc_checker: port-level assertions for the page allocator, bound to the top level
// depends on palloc_pkg and page_allocator_with_refcounts_top
module palloc_checker
   import palloc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // count memory clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_tready)
      else $error("request accepted before count clearing");

   // bad address reports neither a page nor a count
   a_bad_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == ST_BAD_ADDR) |-> (rsp_tdata[38:3] == '0))
      else $error("bad address response carries data");

   // a nonzero page address only comes from a successful allocation with count one
   a_alloc_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[30:3] != '0) |->
         (rsp_tdata[2:0] == ST_OK) && (rsp_tdata[38:31] == 8'd1))
      else $error("page address without a successful allocation");

endmodule

bind page_allocator_with_refcounts_top palloc_checker u_palloc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/tb_page_allocator_with_refcounts_top.sv */
`timescale 1ns / 1ps
// tb_page_allocator_with_refcounts_top: self-checking bench for the page frame allocator
// drives a directed table and random traffic, checks fixed rows against typed values and
// others against a model of the free list and counts; depends on palloc_pkg and the top level
module tb_page_allocator_with_refcounts_top;
   import palloc_pkg::*;

   localparam logic [2:0] CMD_SPARE0   = 3'd6;
   localparam logic [2:0] CMD_SPARE1   = 3'd7;
   localparam logic [7:0] REF_LIMIT    = 8'hFF;
   localparam int         STALL_LIMIT  = 200000;
   localparam int         HOLD_CYCLES  = 400;

   typedef struct packed {
      status_type  status;
      logic [27:0] page_addr;
      logic [7:0]  ref_count;
      logic [16:0] free_count;
   } page_outcome_type;

   typedef struct {
      logic [2:0]       cmd;
      logic [31:0]      addr;
      bit               fixed;
      page_outcome_type outcome;
   } page_cmd_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   // model of the allocator state
   bit [15:0]   frame_link [0:65535];
   bit          frame_link_set [0:65535];
   bit [7:0]    frame_refs [0:65535];
   logic [15:0] list_top = '0;
   bit          list_live = 1'b0;
   logic [16:0] free_total = '0;
   logic [15:0] first_page = '0;

   page_outcome_type page_cmd_outcomes[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          req_gap_pct = 0;
   int          rsp_gap_pct = 0;
   bit          hold_pending = 1'b0;
   int          hold_left = 0;

   // directed part: expected values typed in only for the obvious rows
   page_cmd_row_type dir_rows [0:23] = '{
      '{CMD_ALLOC,  32'h0000_0000, 1'b1, '{ST_EMPTY,     28'h0, 8'h0, 17'h0}},
      '{CMD_NFREE,  32'h0000_0000, 1'b1, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_SPARE0, 32'hFFFF_FFFF, 1'b1, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_SPARE1, 32'hFFFF_FFFF, 1'b1, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_FREE,   32'h0000_0001, 1'b1, '{ST_BAD_ADDR,  28'h0, 8'h0, 17'h0}},
      '{CMD_GET,    32'h1000_0000, 1'b1, '{ST_BAD_ADDR,  28'h0, 8'h0, 17'h0}},
      '{CMD_INC,    32'hFFFF_FFFF, 1'b1, '{ST_BAD_ADDR,  28'h0, 8'h0, 17'h0}},
      '{CMD_DEC,    32'h0000_5000, 1'b1, '{ST_UNDERFLOW, 28'h0, 8'h0, 17'h0}},
      '{CMD_FREE,   32'h0000_0000, 1'b1, '{ST_OK,        28'h0, 8'h0, 17'h1}},
      '{CMD_FREE,   32'h0FFF_F000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_FREE,   32'h0000_7000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_GET,    32'h0000_7000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_ALLOC,  32'h0000_0000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_INC,    32'h0000_7000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_FREE,   32'h0000_7000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_ALLOC,  32'hFFFF_FFFF, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_INC,    32'h0000_0000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_ALLOC,  32'h0000_0000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_DEC,    32'h0000_0000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_FREE,   32'h0000_0000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_ALLOC,  32'h0000_0000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_ALLOC,  32'h0000_0000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_NFREE,  32'h0000_0000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}},
      '{CMD_GET,    32'h0FFF_F000, 1'b0, '{ST_OK,        28'h0, 8'h0, 17'h0}}
   };

   page_allocator_with_refcounts_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),     // first_usable_page
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [31:0] phys_addr
      .req_tuser  (req_tuser),    // [2:0] cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [2:0] status, [30:3] page_addr, [38:31] ref_count,
                                  // [55:39] free_count
   );

   always #1 clock = ~clock;

   function automatic page_outcome_type apply_page_cmd(input logic [2:0] c,
                                                       input logic [31:0] a);
      page_outcome_type r;
      logic [15:0]   pg;
      logic [15:0]   top;
      logic [7:0]    cnt;
      bit            addr_ok;
      r = '{ST_OK, 28'h0, 8'h0, 17'h0};
      pg = a[27:12];
      addr_ok = (a[11:0] == 12'h000) && (a[31:28] == 4'h0) && (pg >= first_page);
      case (c)
         CMD_ALLOC: begin
            if (!list_live) begin
               r.status = ST_EMPTY;
            end else begin
               top = list_top;
               if (frame_refs[top] != 8'd0) begin
                  // head page still referenced, list left alone
                  r.status = ST_BUSY;
                  r.ref_count = frame_refs[top];
               end else begin
                  list_top = frame_link[top];
                  list_live = frame_link_set[top];
                  frame_refs[top] = 8'd1;
                  r.ref_count = 8'd1;
                  if (free_total != 17'd0) free_total--;
                  r.page_addr = {top, 12'h000};
               end
            end
         end
         CMD_FREE, CMD_INC, CMD_DEC, CMD_GET: begin
            if (!addr_ok) begin
               r.status = ST_BAD_ADDR;
            end else begin
               cnt = frame_refs[pg];
               if (c == CMD_FREE) begin
                  if (cnt > 8'd1) begin
                     cnt--;
                  end else begin
                     // pushed even when already on the list
                     frame_link[pg] = list_top;
                     frame_link_set[pg] = list_live;
                     list_top = pg;
                     list_live = 1'b1;
                     cnt = 8'd0;
                     if (free_total != FREE_MAX) free_total++;
                  end
               end else if (c == CMD_INC) begin
                  if (cnt == REF_LIMIT) r.status = ST_OVERFLOW;
                  else cnt++;
               end else if (c == CMD_DEC) begin
                  if (cnt == 8'd0) r.status = ST_UNDERFLOW;
                  else cnt--;
               end
               frame_refs[pg] = cnt;
               r.ref_count = cnt;
            end
         end
         default: ;
      endcase
      r.free_count = free_total;
      return r;
   endfunction

   task automatic send_cmd(input logic [2:0] c, input logic [31:0] a,
                           input bit fixed = 1'b0, input page_outcome_type fixed_outcome = '0);
      page_outcome_type pred;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= a;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      pred = apply_page_cmd(c, a);
      page_cmd_outcomes.push_back(fixed ? fixed_outcome : pred);
   endtask

   // stop offering and let every outstanding response come back
   task automatic settle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (page_cmd_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_first_page(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      first_page = v;
   endtask

   task automatic run_traffic(input int n);
      int          pick;
      logic [2:0]  c;
      logic [16:0] pg;
      logic [31:0] a;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 24)      c = CMD_ALLOC;
         else if (pick < 54) c = CMD_FREE;
         else if (pick < 68) c = CMD_INC;
         else if (pick < 80) c = CMD_DEC;
         else if (pick < 89) c = CMD_GET;
         else if (pick < 95) c = CMD_NFREE;
         else if (pick < 98) c = CMD_SPARE0;
         else                c = CMD_SPARE1;
         // small page pool just above the floor so frees and allocs keep meeting
         pg = 17'(first_page) + 17'($urandom_range(0, 11));
         if (pg > 17'h0FFFF || $urandom_range(0, 19) == 0) pg = 17'h0FFFF;
         a = {4'h0, pg[15:0], 12'h000};
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: a[11:0] = 12'($urandom_range(1, 4095));
               1: begin
                  if (first_page != 16'd0)
                     a = {4'h0, 16'($urandom_range(0, first_page - 1)), 12'h000};
                  else
                     a[31:28] = 4'($urandom_range(1, 15));
               end
               2: a[31:28] = 4'($urandom_range(1, 15));
               default: a = $urandom();
            endcase
         end
         send_cmd(c, a);
      end
   endtask

   // response side: random backpressure plus one long hold-off
   always @(posedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_gap_pct);
      end
   end

   always @(posedge clock) begin
      page_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (page_cmd_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response transaction: %h", rsp_tdata);
         end else begin
            want = page_cmd_outcomes.pop_front();
            if (rsp_tdata[2:0] !== want.status || rsp_tdata[30:3] !== want.page_addr ||
                rsp_tdata[38:31] !== want.ref_count || rsp_tdata[55:39] !== want.free_count)
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d pa %h rc %0d fc %0d, got st %0d pa %h rc %0d fc %0d",
                           want.status, want.page_addr, want.ref_count, want.free_count,
                           rsp_tdata[2:0], rsp_tdata[30:3], rsp_tdata[38:31], rsp_tdata[55:39]);
            end
         end
      end
   end

   // watchdog on cycles without any transaction; covers the clearing pass after reset
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_page_allocator_with_refcounts_top: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_first_page(16'd0);

      req_gap_pct = 28;
      rsp_gap_pct = 71;
      foreach (dir_rows[i])
         send_cmd(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].fixed, dir_rows[i].outcome);
      // walk one count up into overflow and back down into underflow
      repeat (256) send_cmd(CMD_INC, 32'h0000_3000);
      send_cmd(CMD_GET, 32'h0000_3000);
      repeat (256) send_cmd(CMD_DEC, 32'h0000_3000);
      settle();
      write_first_page(16'($urandom_range(1, 60000)));
      run_traffic(150);
      settle();

      req_gap_pct = 71;
      rsp_gap_pct = 28;
      write_first_page(16'hFFFF);
      run_traffic(60);
      settle();
      write_first_page(16'($urandom_range(1, 1000)));
      run_traffic(100);
      settle();

      req_gap_pct = 0;
      rsp_gap_pct = 0;
      write_first_page(16'd0);
      hold_pending = 1'b1;
      run_traffic(100);
      settle();
      repeat (4) send_cmd(CMD_ALLOC, 32'h0000_0000);
      send_cmd(CMD_NFREE, 32'h0000_0000);
      settle();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && page_cmd_outcomes.size() == 0)
         $display("tb_page_allocator_with_refcounts_top: done, clean");
      else
         $display("tb_page_allocator_with_refcounts_top: done, errors");
      $finish;
   end

endmodule
